FILE: hdl/half_step_stepper_sequencer_defines.svh
// ----------------------------------------------------------------------------
// Half-step stepper sequencer assertion macros
// Clocked, reset-gated immediate-implication and next-cycle-implication
// property macros used by the checker file.
// ----------------------------------------------------------------------------
`ifndef HALF_STEP_STEPPER_SEQUENCER_DEFINES_SVH
`define HALF_STEP_STEPPER_SEQUENCER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define HSSQ_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define HSSQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/hssq_pkg.sv
// ----------------------------------------------------------------------------
// Half-step stepper sequencer package
// Request and result types, configuration types, register indexes and the
// eight-phase half-step coil pattern.
// ----------------------------------------------------------------------------
`default_nettype none

package hssq_pkg;

  // Fixed field widths
  localparam int POS_W   = 16;
  localparam int STEPS_W = 16;
  localparam int COIL_W  = 4;
  localparam int SPR_W   = 16;
  localparam int DLY_W   = 32;
  localparam int WDATA_W = 32;

  // Default parameter values and register reset values
  localparam int DELAY_BITS_DEF = 32;
  localparam logic [SPR_W-1:0] SPR_RESET = 16'd4096;
  localparam logic [DLY_W-1:0] DLY_RESET = 32'd1000;

  // Request command codes
  localparam logic CMD_TICK = 1'b0;
  localparam logic CMD_MOVE = 1'b1;

  // Register indexes
  typedef enum logic [0:0] {
    CFG_STEPS_PER_REV = 1'b0,
    CFG_TICK_DELAY    = 1'b1
  } hssq_cfg_idx_t;

  typedef struct packed {
    logic [SPR_W-1:0] steps_per_rev;
    logic [DLY_W-1:0] tick_delay;
  } hssq_cfg_t;

  // Input request: command 0 = tick, 1 = start a move
  typedef struct packed {
    logic                      command;
    logic signed [STEPS_W-1:0] move_steps;
  } hssq_cmd_t;

  typedef struct packed {
    logic [COIL_W-1:0]  coils;
    logic [POS_W-1:0]   position;
    logic [STEPS_W-1:0] steps_pending;
    logic               busy_res;
    logic               move_done;
    logic               rejected;
  } hssq_res_t;

  // Eight-phase half-step coil pattern, bit3 coil1 .. bit0 coil4
  function automatic logic [COIL_W-1:0] hssq_pattern(input logic [2:0] phase);
    logic [COIL_W-1:0] pat;
    unique case (phase)
      3'd0:    pat = 4'h1;
      3'd1:    pat = 4'h3;
      3'd2:    pat = 4'h2;
      3'd3:    pat = 4'h6;
      3'd4:    pat = 4'h4;
      3'd5:    pat = 4'hC;
      3'd6:    pat = 4'h8;
      default: pat = 4'h9;
    endcase
    return pat;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/half_step_stepper_sequencer.sv
// ----------------------------------------------------------------------------
// Half-step stepper sequencer
// Eight-phase half-step drive for a four-coil unipolar stepper, with move
// requests, tick timebase and configurable step delay and revolution length.
// ----------------------------------------------------------------------------
// The block takes one request per clock and returns one result per request.
// The request lands in an input register, the motion state is updated from it
// by combinational logic, and the result is held in an output register. Since
// that update is combinational, ticks may arrive on every clock; only a stalled
// result slows the input side. Write the revolution length and tick delay
// registers only while no request is in flight.
`default_nettype none

module half_step_stepper_sequencer
  import hssq_pkg::*;
#(
  parameter int DELAY_BITS = DELAY_BITS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cmd_valid,
  output logic                     cmd_stall,
  input  wire hssq_cmd_t           cmd,
  output logic                     res_valid,
  input  wire logic                res_stall,
  output hssq_res_t                res,
  input  wire logic                wr_en,
  input  wire hssq_cfg_idx_t       wr_index,
  input  wire logic [WDATA_W-1:0]  wr_data
);

  hssq_cfg_t cfg;
  hssq_cmd_t req;
  logic      req_valid;
  logic      res_free;
  logic      go;
  hssq_res_t res_next;

  hssq_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .cfg      (cfg)
  );

  hssq_core #(
    .DELAY_BITS (DELAY_BITS)
  ) u_core (
    .clk      (clk),
    .rst      (rst),
    .go       (go),
    .cmd      (req),
    .cfg      (cfg),
    .res_next (res_next)
  );

  // Handshake: advance when the result register can take a new value
  always_comb begin
    res_free  = !res_valid || !res_stall;
    go        = req_valid && res_free;
    cmd_stall = req_valid && !res_free;
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (!cmd_stall) begin
      req_valid <= cmd_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!cmd_stall) begin
      req <= cmd;
    end
  end

  // Result register: hold while stalled
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_free) begin
      res_valid <= go;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      res <= res_next;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/hssq_cfg.sv
// ----------------------------------------------------------------------------
// Half-step stepper sequencer configuration registers
// Holds steps per revolution and step delay, written through a plain port.
// ----------------------------------------------------------------------------
`default_nettype none

module hssq_cfg
  import hssq_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                wr_en,
  input  wire hssq_cfg_idx_t       wr_index,
  input  wire logic [WDATA_W-1:0]  wr_data,
  output hssq_cfg_t                cfg
);

  // Decode the index and capture the write
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.steps_per_rev <= SPR_RESET;
      cfg.tick_delay    <= DLY_RESET;
    end else if (wr_en) begin
      unique case (wr_index)
        CFG_STEPS_PER_REV: cfg.steps_per_rev <= wr_data[SPR_W-1:0];
        CFG_TICK_DELAY:    cfg.tick_delay    <= wr_data[DLY_W-1:0];
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: hdl/hssq_core.sv
// ----------------------------------------------------------------------------
// Half-step stepper sequencer core
// Motion state (position, direction, steps remaining, elapsed ticks, coil
// drive) and the combinational next-state update for one request.
// ----------------------------------------------------------------------------
`default_nettype none

module hssq_core
  import hssq_pkg::*;
#(
  parameter int DELAY_BITS = DELAY_BITS_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      go,
  input  wire hssq_cmd_t cmd,
  input  wire hssq_cfg_t cfg,
  output hssq_res_t      res_next
);

  localparam int CMP_W = (DELAY_BITS > DLY_W) ? DELAY_BITS : DLY_W;

  logic [POS_W-1:0]      position;
  logic                  forward;
  logic [STEPS_W-1:0]    remaining;
  logic [DELAY_BITS-1:0] elapsed;
  logic [COIL_W-1:0]     coil;

  logic [POS_W-1:0]      position_next;
  logic                  forward_next;
  logic [STEPS_W-1:0]    remaining_next;
  logic [DELAY_BITS-1:0] elapsed_next;
  logic [COIL_W-1:0]     coil_next;
  logic                  done;
  logic                  rej;

  logic [DELAY_BITS-1:0] elapsed_inc;
  logic                  step_due;
  logic [STEPS_W-1:0]    raw;
  logic [POS_W-1:0]      pos_inc;
  logic [POS_W-1:0]      rev_base;
  logic [POS_W-1:0]      pos_adv;

  // Saturating tick count and the step-due compare
  always_comb begin
    elapsed_inc = (elapsed == '1) ? elapsed : elapsed + 1'b1;
    step_due    = (remaining != '0) &&
                  (CMP_W'(elapsed_inc) >= CMP_W'(cfg.tick_delay));
  end

  // Advance the position one step, wrapping within the revolution
  always_comb begin
    pos_inc  = position + 1'b1;
    rev_base = (position == '0) ? cfg.steps_per_rev : position;
    if (forward) begin
      pos_adv = (pos_inc == cfg.steps_per_rev) ? '0 : pos_inc;
    end else begin
      pos_adv = rev_base - 1'b1;
    end
  end

  // Next state for one request
  always_comb begin
    raw            = cmd.move_steps;
    position_next  = position;
    forward_next   = forward;
    remaining_next = remaining;
    elapsed_next   = elapsed;
    coil_next      = coil;
    done           = 1'b0;
    rej            = 1'b0;
    if (go) begin
      if (cmd.command == CMD_MOVE) begin
        // Move: reject while busy, ignore a zero count
        if (remaining != '0) begin
          rej = 1'b1;
        end else if (raw != '0) begin
          forward_next   = !raw[STEPS_W-1];
          remaining_next = raw[STEPS_W-1] ? (~raw + 1'b1) : raw;
        end
      end else begin
        // Tick: count, and step when the delay has run out
        elapsed_next = elapsed_inc;
        if (step_due) begin
          elapsed_next   = '0;
          position_next  = pos_adv;
          remaining_next = remaining - 1'b1;
          if (remaining == STEPS_W'(1)) begin
            coil_next = '0;
            done      = 1'b1;
          end else begin
            coil_next = hssq_pattern(pos_adv[2:0]);
          end
        end
      end
    end
  end

  // Result built from the updated state
  always_comb begin
    res_next.coils         = coil_next;
    res_next.position      = position_next;
    res_next.steps_pending = remaining_next;
    res_next.busy_res      = (remaining_next != '0);
    res_next.move_done     = done;
    res_next.rejected      = rej;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position  <= '0;
      forward   <= 1'b0;
      remaining <= '0;
      elapsed   <= '0;
      coil      <= '0;
    end else begin
      position  <= position_next;
      forward   <= forward_next;
      remaining <= remaining_next;
      elapsed   <= elapsed_next;
      coil      <= coil_next;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/hssq_checker.sv
// ----------------------------------------------------------------------------
// Half-step stepper sequencer checker
// Port-level checks of the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "half_step_stepper_sequencer_defines.svh"

module hssq_checker
  import hssq_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst,
  input wire logic      res_valid,
  input wire logic      res_stall,
  input wire hssq_res_t res
);

  // Hold a stalled result
  `HSSQ_ASSERT_NEXT(a_res_hold, res_valid && res_stall, res_valid && $stable(res), "held")

  // Busy flag tracks the steps still to take
  `HSSQ_ASSERT_SAME(a_busy_steps, res_valid, res.busy_res == (res.steps_pending != '0), "busy")

  // Coils are released whenever no move is in progress
  `HSSQ_ASSERT_SAME(a_idle_released, res_valid && !res.busy_res, res.coils == '0, "idle coils")

  // A rejected move only happens while busy, and never on a finishing step
  `HSSQ_ASSERT_SAME(a_reject_busy, res_valid && res.rejected, res.busy_res && !res.move_done, "reject")

endmodule

bind half_step_stepper_sequencer hssq_checker u_checker (.*);

`default_nettype wire
